@@ hdl/rup_pkg.sv @@
// ----------------------------------------------------------------------------
// rup_pkg
// Shared widths, bounds, register indexes and beat types for the RGBA
// unpremultiply readback block.
// ----------------------------------------------------------------------------
package rup_pkg;

   localparam int MAX_WIDTH       = 8192;
   localparam int MAX_HEIGHT      = 8192;
   localparam int MAX_PITCH_WORDS = 16384;

   localparam int WIDTH_BITS  = 14;
   localparam int HEIGHT_BITS = 14;
   localparam int PITCH_BITS  = 15;
   localparam int COL_BITS    = 14;
   localparam int ROW_BITS    = 13;
   localparam int CSR_BITS    = 15;
   localparam int CSR_IDX_BITS = 2;

   localparam int CHAN_BITS   = 8;
   localparam int NUM_LANES   = 3;
   localparam int NUM_BITS    = 16;
   localparam int STEP_BITS   = 4;

   localparam logic [CHAN_BITS-1:0] CHAN_MAX  = 8'd255;
   localparam logic [CHAN_BITS-1:0] CHAN_ZERO = 8'd0;

   localparam logic [CSR_IDX_BITS-1:0] REG_FRAME_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] REG_FRAME_HEIGHT = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] REG_ROW_PITCH    = 2'd2;
   localparam logic [CSR_IDX_BITS-1:0] REG_KEEP_PREMUL  = 2'd3;

   // Work handed to one lane.
   typedef struct packed {
      logic [CHAN_BITS-1:0] color;
      logic [CHAN_BITS-1:0] alpha;
      logic                 bypass;
   } lane_cmd_type;

   // What one lane reports back.
   typedef struct packed {
      logic                 busy;
      logic [CHAN_BITS-1:0] result;
   } lane_out_type;

   // Side information of the beat waiting for the lanes.
   typedef struct packed {
      logic                 valid;
      logic                 pitch_error;
      logic                 end_of_row;
      logic                 end_of_frame;
      logic [CHAN_BITS-1:0] alpha;
   } pend_type;

endpackage

@@ hdl/rup_lane.sv @@
// ----------------------------------------------------------------------------
// rup_lane
// One color channel: straightens a premultiplied byte by its alpha with a
// restoring divider that retires one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rup_lane (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  rup_pkg::lane_cmd_type cmd,
   output rup_pkg::lane_out_type status
);
   import rup_pkg::*;

   logic                 busy_ff, busy_in;
   logic [STEP_BITS-1:0] step_ff, step_in;
   logic [NUM_BITS-1:0]  work_ff, work_in;
   logic [CHAN_BITS-1:0] rem_ff, rem_in;
   logic [CHAN_BITS-1:0] divisor_ff, divisor_in;
   logic [CHAN_BITS-1:0] result_ff, result_in;

   logic [NUM_BITS-1:0]  numerator;
   logic [CHAN_BITS:0]   trial;
   logic [CHAN_BITS:0]   diff;
   logic                 qbit;
   logic [NUM_BITS-1:0]  work_next;

   // c*255 + a/2, which never exceeds 16 bits.
   assign numerator = ({cmd.color, 8'h00} - {8'h00, cmd.color})
                    + {9'h000, cmd.alpha[CHAN_BITS-1:1]};

   assign trial     = {rem_ff, work_ff[NUM_BITS-1]};
   assign diff      = trial - {1'b0, divisor_ff};
   assign qbit      = (trial >= {1'b0, divisor_ff});
   assign work_next = {work_ff[NUM_BITS-2:0], qbit};

   always_comb begin
      busy_in    = busy_ff;
      step_in    = step_ff;
      work_in    = work_ff;
      rem_in     = rem_ff;
      divisor_in = divisor_ff;
      result_in  = result_ff;
      if (busy_ff) begin
         work_in = work_next;
         rem_in  = qbit ? diff[CHAN_BITS-1:0] : trial[CHAN_BITS-1:0];
         step_in = step_ff + 1'b1;
         if (step_ff == {STEP_BITS{1'b1}}) begin
            busy_in   = 1'b0;
            // A quotient above one byte saturates.
            result_in = (|work_next[NUM_BITS-1:CHAN_BITS]) ? CHAN_MAX
                                                          : work_next[CHAN_BITS-1:0];
         end
      end else if (start) begin
         if (cmd.bypass || cmd.alpha == CHAN_MAX) begin
            result_in = cmd.color;
         end else if (cmd.alpha == CHAN_ZERO) begin
            result_in = CHAN_ZERO;
         end else begin
            busy_in    = 1'b1;
            step_in    = '0;
            work_in    = numerator;
            rem_in     = '0;
            divisor_in = cmd.alpha;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         step_ff <= step_in;
      end
      work_ff    <= work_in;
      rem_ff     <= rem_in;
      divisor_ff <= divisor_in;
      result_ff  <= result_in;
   end

   assign status.busy   = busy_ff;
   assign status.result = result_ff;

endmodule

@@ hdl/rup_merge.sv @@
// ----------------------------------------------------------------------------
// rup_merge
// Joins the three lane results with the pending side information and holds
// the finished beat in the output register until it is taken.
// ----------------------------------------------------------------------------
module rup_merge (
   input  logic                  clock,
   input  logic                  reset,
   input  rup_pkg::pend_type     pend,
   input  rup_pkg::lane_out_type lane_red,
   input  rup_pkg::lane_out_type lane_green,
   input  rup_pkg::lane_out_type lane_blue,
   output logic                  take,
   input  logic                  rsp_tready,
   output logic                  rsp_tvalid,
   output logic [31:0]           rsp_tdata,
   output logic                  rsp_tlast,
   output logic [1:0]            rsp_tuser
);
   import rup_pkg::*;

   logic        valid_ff, valid_in;
   logic [31:0] data_ff, data_in;
   logic        last_ff, last_in;
   logic [1:0]  user_ff, user_in;
   logic        lanes_busy;

   assign lanes_busy = lane_red.busy | lane_green.busy | lane_blue.busy;
   assign take       = pend.valid && !lanes_busy && (!valid_ff || rsp_tready);

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      last_in  = last_ff;
      user_in  = user_ff;
      if (take) begin
         valid_in = 1'b1;
         if (pend.pitch_error) begin
            data_in = '0;
            last_in = 1'b0;
            user_in = 2'b10;
         end else begin
            data_in = {pend.alpha, lane_blue.result, lane_green.result, lane_red.result};
            last_in = pend.end_of_row;
            user_in = {1'b0, pend.end_of_frame};
         end
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
      last_ff <= last_in;
      user_ff <= user_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tlast  = last_ff;
   assign rsp_tuser  = user_ff;

endmodule

@@ hdl/rgba_unpremultiply_readback.sv @@
// ----------------------------------------------------------------------------
// rgba_unpremultiply_readback
// Turns a readback stream of premultiplied RGBA8 words into straight-alpha
// pixels, dropping row padding and marking row and frame ends.
// ----------------------------------------------------------------------------
//   channel  dir  handshake             payload
//   req_     in   tvalid/tready         tdata: red, green, blue, alpha
//   rsp_     out  tvalid/tready/tlast   tdata: red, green, blue, alpha;
//                                       tlast: end of row; tuser: frame, error
//   csr_     in   we                    index, wdata (no read-back)
//
// A pixel that needs a divide is worked by the 16-step restoring divider in
// each of the three lanes in parallel. Pass-through, alpha 0 or 255, and pitch
// error beats skip the divider; padding words make no beat. A new word is
// accepted only while no beat is pending. A finished beat waits in the output
// register, so one more pixel may be accepted and worked on while rsp_tready is low.
// Reset is synchronous and restores the configuration registers, the valid and busy flags and the position counters.
// ----------------------------------------------------------------------------
module rgba_unpremultiply_readback (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [31:0]                      req_tdata,   // src_red, src_green, src_blue, src_alpha
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [31:0]                      rsp_tdata,   // out_red, out_green, out_blue, out_alpha
   output logic                             rsp_tlast,
   output logic [1:0]                       rsp_tuser,   // end_of_frame, pitch_error
   input  logic                             csr_we,
   input  logic [rup_pkg::CSR_IDX_BITS-1:0] csr_index,
   input  logic [rup_pkg::CSR_BITS-1:0]     csr_wdata
);
   import rup_pkg::*;

   logic [WIDTH_BITS-1:0]  width_ff, width_in;
   logic [HEIGHT_BITS-1:0] height_ff, height_in;
   logic [PITCH_BITS-1:0]  pitch_ff, pitch_in;
   logic                   keep_ff, keep_in;
   logic [COL_BITS-1:0]    col_ff, col_in;
   logic [ROW_BITS-1:0]    row_ff, row_in;
   pend_type               pend_ff, pend_in;

   logic [WIDTH_BITS-1:0]  w_eff;
   logic [HEIGHT_BITS-1:0] h_eff;
   logic [PITCH_BITS-1:0]  p_eff;
   logic [COL_BITS:0]      col_p1;
   logic [ROW_BITS:0]      row_p1;
   logic                   accept, err, visible, last_row, last_word, row_end;
   logic                   lane_start, take;
   lane_cmd_type           cmd [NUM_LANES];
   lane_out_type           lane [NUM_LANES];

   // Zero counts as one and values past the limits saturate.
   assign w_eff = (width_ff == '0) ? WIDTH_BITS'(1)
                : (width_ff > WIDTH_BITS'(MAX_WIDTH)) ? WIDTH_BITS'(MAX_WIDTH) : width_ff;
   assign h_eff = (height_ff == '0) ? HEIGHT_BITS'(1)
                : (height_ff > HEIGHT_BITS'(MAX_HEIGHT)) ? HEIGHT_BITS'(MAX_HEIGHT) : height_ff;
   assign p_eff = (pitch_ff == '0) ? PITCH_BITS'(1)
                : (pitch_ff > PITCH_BITS'(MAX_PITCH_WORDS)) ? PITCH_BITS'(MAX_PITCH_WORDS)
                : pitch_ff;

   assign col_p1    = {1'b0, col_ff} + 1'b1;
   assign row_p1    = {1'b0, row_ff} + 1'b1;
   assign err       = p_eff < {1'b0, w_eff};
   assign visible   = col_ff < w_eff;
   assign last_row  = row_p1 >= h_eff;
   assign last_word = col_p1 >= p_eff;
   assign row_end   = col_p1 == {1'b0, w_eff};

   assign req_tready = !pend_ff.valid;
   assign accept     = req_tvalid && req_tready;
   assign lane_start = accept && visible && !err;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      pitch_in  = pitch_ff;
      keep_in   = keep_ff;
      if (csr_we) begin
         unique case (csr_index)
            REG_FRAME_WIDTH:  width_in  = csr_wdata[WIDTH_BITS-1:0];
            REG_FRAME_HEIGHT: height_in = csr_wdata[HEIGHT_BITS-1:0];
            REG_ROW_PITCH:    pitch_in  = csr_wdata[PITCH_BITS-1:0];
            REG_KEEP_PREMUL:  keep_in   = csr_wdata[0];
            default:          keep_in   = keep_ff;
         endcase
      end
   end

   always_comb begin
      col_in  = col_ff;
      row_in  = row_ff;
      pend_in = pend_ff;
      if (take) begin
         pend_in.valid = 1'b0;
      end
      if (accept) begin
         if (err) begin
            // Counters hold while the pitch is too small.
            pend_in.valid       = 1'b1;
            pend_in.pitch_error = 1'b1;
            pend_in.end_of_row  = 1'b0;
            pend_in.end_of_frame = 1'b0;
            pend_in.alpha       = CHAN_ZERO;
         end else begin
            if (visible) begin
               pend_in.valid        = 1'b1;
               pend_in.pitch_error  = 1'b0;
               pend_in.end_of_row   = row_end;
               pend_in.end_of_frame = row_end && last_row;
               pend_in.alpha        = req_tdata[31:24];
            end
            if (last_word) begin
               col_in = '0;
               row_in = last_row ? '0 : row_p1[ROW_BITS-1:0];
            end else begin
               col_in = col_p1[COL_BITS-1:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff      <= WIDTH_BITS'(1);
         height_ff     <= HEIGHT_BITS'(1);
         pitch_ff      <= PITCH_BITS'(1);
         keep_ff       <= 1'b0;
         col_ff        <= '0;
         row_ff        <= '0;
         pend_ff.valid <= 1'b0;
      end else begin
         width_ff      <= width_in;
         height_ff     <= height_in;
         pitch_ff      <= pitch_in;
         keep_ff       <= keep_in;
         col_ff        <= col_in;
         row_ff        <= row_in;
         pend_ff.valid <= pend_in.valid;
      end
      pend_ff.pitch_error  <= pend_in.pitch_error;
      pend_ff.end_of_row   <= pend_in.end_of_row;
      pend_ff.end_of_frame <= pend_in.end_of_frame;
      pend_ff.alpha        <= pend_in.alpha;
   end

   for (genvar i = 0; i < NUM_LANES; i++) begin : g_lane
      assign cmd[i].color  = req_tdata[CHAN_BITS*i +: CHAN_BITS];
      assign cmd[i].alpha  = req_tdata[31:24];
      assign cmd[i].bypass = keep_ff;

      rup_lane u_lane (
         .clock  (clock),
         .reset  (reset),
         .start  (lane_start),
         .cmd    (cmd[i]),
         .status (lane[i])
      );
   end

   rup_merge u_merge (
      .clock      (clock),
      .reset      (reset),
      .pend       (pend_ff),
      .lane_red   (lane[0]),
      .lane_green (lane[1]),
      .lane_blue  (lane[2]),
      .take       (take),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   // The lanes only work on the beat that is pending.
   a_busy_pending: assert property (@(posedge clock) disable iff (reset)
      (lane[0].busy || lane[1].busy || lane[2].busy) |-> pend_ff.valid)
      else $error("lane busy without a pending beat");

   // All three lanes start together and run the same number of steps.
   a_lockstep: assert property (@(posedge clock) disable iff (reset)
      (lane[0].busy == lane[1].busy) && (lane[1].busy == lane[2].busy))
      else $error("lanes out of step");

   // An error beat carries no pixel and no row or frame mark.
   a_error_beat: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[1]) |-> (rsp_tdata == '0 && !rsp_tlast && !rsp_tuser[0]))
      else $error("pitch error beat with payload");

   // A frame end is always also a row end.
   a_frame_row: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[0]) |-> rsp_tlast)
      else $error("frame end without row end");

endmodule
